// ----- rtl/sopll_pkg.sv -----
// shared types, constants and the arctangent table of the carrier loop
package sopll_pkg;

   localparam int ATAN_COUNT  = 24;
   localparam int STEP_W      = 5;
   localparam int CSR_INDEX_W = 3;
   // angle register width: 32-bit turns plus guard bits for the rotation fill
   localparam int ZW          = 34;
   // cordic start magnitude, gain-compensated unit vector in Q2.30
   localparam logic [31:0] ROT_X0     = 32'd652032874;
   localparam logic [31:0] QUARTER    = 32'h4000_0000;
   localparam logic [31:0] HALF_TURN  = 32'h8000_0000;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_START_INCREMENT = 3'd0,
      CSR_LOW_LIMIT       = 3'd1,
      CSR_HIGH_LIMIT      = 3'd2,
      CSR_PROP_GAIN       = 3'd3,
      CSR_INT_GAIN        = 3'd4
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_FILL_INIT,
      ST_FILL_ITER,
      ST_FILL_WRITE,
      ST_IDLE,
      ST_MIX_MUL,
      ST_MIX_SAT,
      ST_VECTOR,
      ST_ERROR,
      ST_GAIN,
      ST_UPDATE
   } state_type;

   typedef struct packed {
      logic              load;
      logic              step;
      logic              vectoring;
      logic [STEP_W-1:0] index;
   } cordic_ctrl_type;

   // atan(2^-k) in 2^-32 turns
   function automatic logic [29:0] atan_turns(input logic [STEP_W-1:0] idx);
      logic [29:0] r;
      begin
         case (idx)
            5'd0:    r = 30'd536870912;
            5'd1:    r = 30'd316933406;
            5'd2:    r = 30'd167458907;
            5'd3:    r = 30'd85004756;
            5'd4:    r = 30'd42667331;
            5'd5:    r = 30'd21354465;
            5'd6:    r = 30'd10679838;
            5'd7:    r = 30'd5340245;
            5'd8:    r = 30'd2670163;
            5'd9:    r = 30'd1335087;
            5'd10:   r = 30'd667544;
            5'd11:   r = 30'd333772;
            5'd12:   r = 30'd166886;
            5'd13:   r = 30'd83443;
            5'd14:   r = 30'd41722;
            5'd15:   r = 30'd20861;
            5'd16:   r = 30'd10430;
            5'd17:   r = 30'd5215;
            5'd18:   r = 30'd2608;
            5'd19:   r = 30'd1304;
            5'd20:   r = 30'd652;
            5'd21:   r = 30'd326;
            5'd22:   r = 30'd163;
            5'd23:   r = 30'd81;
            default: r = 30'd0;
         endcase
         return r;
      end
   endfunction

endpackage

// ----- rtl/sopll_if.sv -----
// handshake channels of the carrier loop: sample in, result out, register write
interface sopll_req_if #(parameter int SAMPLE_BITS = 16) ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample_i;
   logic signed [SAMPLE_BITS-1:0] sample_q;
   modport source (output valid, sample_i, sample_q, input ready);
   modport sink   (input valid, sample_i, sample_q, output ready);
endinterface

interface sopll_rsp_if #(parameter int SAMPLE_BITS = 16) ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] mixed_i;
   logic signed [SAMPLE_BITS-1:0] mixed_q;
   logic signed [15:0]            phase_error;
   logic signed [31:0]            frequency_now;
   logic [31:0]                   oscillator_phase;
   logic                          in_lock;
   modport source (output valid, mixed_i, mixed_q, phase_error, frequency_now,
                   oscillator_phase, in_lock, input ready);
   modport sink   (input valid, mixed_i, mixed_q, phase_error, frequency_now,
                   oscillator_phase, in_lock, output ready);
endinterface

interface sopll_csr_if import sopll_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [31:0]            data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/sopll_cordic.sv -----
// shared cordic stage: one micro-rotation per cycle, rotation or vectoring mode
module sopll_cordic import sopll_pkg::*; #(
   parameter int DW = 36
) (
   input  logic                 clock,
   input  cordic_ctrl_type      ctrl,
   input  logic signed [DW-1:0] x_init,
   input  logic signed [DW-1:0] y_init,
   input  logic signed [ZW-1:0] z_init,
   output logic signed [DW-1:0] x_out,
   output logic signed [DW-1:0] y_out,
   output logic signed [ZW-1:0] z_out
);

   logic signed [DW-1:0] x_ff, x_in;
   logic signed [DW-1:0] y_ff, y_in;
   logic signed [ZW-1:0] z_ff, z_in;
   logic signed [DW-1:0] x_sh, y_sh;
   logic signed [ZW-1:0] angle;
   logic                 y_pos;
   logic                 ccw;

   assign x_sh  = x_ff >>> ctrl.index;
   assign y_sh  = y_ff >>> ctrl.index;
   assign angle = {{(ZW-30){1'b0}}, atan_turns(ctrl.index)};
   assign y_pos = !y_ff[DW-1] && (y_ff != '0);
   // vectoring drives y to zero, rotation drives z to zero
   assign ccw   = ctrl.vectoring ? !y_pos : !z_ff[ZW-1];

   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      if (ctrl.load) begin
         x_in = x_init;
         y_in = y_init;
         z_in = z_init;
      end else if (ctrl.step) begin
         if (ccw) begin
            x_in = x_ff - y_sh;
            y_in = y_ff + x_sh;
            z_in = z_ff - angle;
         end else begin
            x_in = x_ff + y_sh;
            y_in = y_ff - x_sh;
            z_in = z_ff + angle;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   assign x_out = x_ff;
   assign y_out = y_ff;
   assign z_out = z_ff;

endmodule

// ----- rtl/second_order_carrier_pll_unit.sv -----
// second-order carrier loop: table oscillator, mixer, cordic phase detector, loop filter
// samples are handled one at a time: a new sample is taken only in the idle state, once the
//   result word of the last one is loaded; the shared cordic stage and the single multiplier
//   run one step per cycle
// reset: the cos/sin table is built by the same cordic, one entry after another (load,
//   rotation steps, write); no sample is taken meanwhile
module second_order_carrier_pll_unit import sopll_pkg::*; #(
   parameter int TABLE_BITS   = 10,
   parameter int PHASE_BITS   = 32,
   parameter int SAMPLE_BITS  = 16,
   parameter int CORDIC_STEPS = 16
) (
   input logic        clock,
   input logic        reset,
   sopll_req_if.sink  req_bus,
   sopll_rsp_if.source rsp_bus,
   sopll_csr_if.sink  csr_bus
);

   localparam int ROM_SIZE = 1 << TABLE_BITS;
   localparam int MB       = (SAMPLE_BITS > 16) ? SAMPLE_BITS : 16;
   localparam int PW       = 33 + MB;
   localparam int MIX_W    = SAMPLE_BITS + 17;
   localparam int DW       = (MIX_W + 3 > 34) ? MIX_W + 3 : 34;
   localparam int MS_W     = MIX_W - 15;
   localparam int RS_W     = DW - 15;
   localparam logic [31:0] PHASE_MASK = ~32'd0 << (32 - PHASE_BITS);
   localparam logic signed [MS_W-1:0] SMAX = MS_W'((1 << (SAMPLE_BITS - 1)) - 1);
   localparam logic signed [MS_W-1:0] SMIN = -SMAX - MS_W'(1);
   localparam logic signed [RS_W-1:0] TMAX = RS_W'(32767);
   localparam logic signed [RS_W-1:0] TMIN = -TMAX;
   localparam logic [STEP_W-1:0] FILL_LAST = STEP_W'(ATAN_COUNT - 1);
   localparam logic [STEP_W-1:0] VEC_LAST  = STEP_W'(CORDIC_STEPS - 1);

   // control
   state_type               state_ff, state_in;
   logic [STEP_W-1:0]       cnt_ff, cnt_in;
   logic [TABLE_BITS-1:0]   fill_idx_ff, fill_idx_in;
   logic                    flip_ff, flip_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   // configuration and loop state
   logic [31:0] start_ff, start_in;
   logic [31:0] lo_ff, lo_in;
   logic [31:0] hi_ff, hi_in;
   logic [31:0] alpha_ff, alpha_in;
   logic [31:0] beta_ff, beta_in;
   logic [31:0] freq_ff, freq_in;
   logic [31:0] phase_ff, phase_in;

   // datapath
   logic signed [SAMPLE_BITS-1:0] si_ff, si_in, sq_ff, sq_in;
   logic [31:0]                   rom_q_ff;
   logic signed [PW-1:0]          prod_ff, prod_in;
   logic signed [MIX_W-1:0]       re_ff, re_in, im_ff, im_in;
   logic signed [SAMPLE_BITS-1:0] mi_ff, mi_in, mq_ff, mq_in;
   logic                          zero_ff, zero_in;
   logic signed [15:0]            err_ff, err_in;
   logic signed [33:0]            f_ff, f_in;
   logic [31:0]                   pterm_ff, pterm_in;
   logic [31:0]                   fnew_ff, fnew_in;
   logic                          lock_ff, lock_in;

   // result word register
   logic signed [SAMPLE_BITS-1:0] out_mi_ff, out_mi_in, out_mq_ff, out_mq_in;
   logic signed [15:0]            out_err_ff, out_err_in;
   logic [31:0]                   out_freq_ff, out_freq_in;
   logic [31:0]                   out_phase_ff, out_phase_in;
   logic                          out_lock_ff, out_lock_in;

   logic [31:0] rom_mem [ROM_SIZE];
   logic        rom_we;
   logic [31:0] rom_wdata;

   cordic_ctrl_type      cctrl;
   logic signed [DW-1:0] cx_init, cy_init, cx, cy;
   logic signed [ZW-1:0] cz_init, cz;

   logic signed [32:0]    mul_a;
   logic signed [MB-1:0]  mul_b;
   logic signed [15:0]    rom_c, rom_s;
   logic                  req_take;
   logic                  cfg_we;
   logic                  out_free;
   logic                  commit;

   // fill-side helpers
   logic [31:0]           fill_a, fill_a_q, fill_a_rot;
   logic                  fill_flip;
   logic signed [DW-1:0]  cx_rnd, cy_rnd;
   logic signed [RS_W-1:0] tc_sh, ts_sh, tc_cl, ts_cl;
   logic signed [15:0]    tc, ts;

   // item-side helpers
   logic signed [MIX_W-1:0] re_rnd, im_rnd;
   logic signed [MS_W-1:0]  re_sh, im_sh, re_cl, im_cl;
   logic signed [DW-1:0]    re_ext, im_ext;
   logic [31:0]             z_rnd;
   logic signed [PW-1:0]    prod_rnd;
   logic signed [32:0]      gain_term;
   logic signed [33:0]      lo_ext, hi_ext;

   sopll_cordic #(.DW(DW)) u_cordic (
      .clock  (clock),
      .ctrl   (cctrl),
      .x_init (cx_init),
      .y_init (cy_init),
      .z_init (cz_init),
      .x_out  (cx),
      .y_out  (cy),
      .z_out  (cz)
   );

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_take      = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;
   assign cfg_we        = csr_bus.valid && csr_bus.ready;
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign commit        = (state_ff == ST_UPDATE) && out_free;

   assign rom_c = rom_q_ff[31:16];
   assign rom_s = rom_q_ff[15:0];

   // table entry angle, brought into the right half-plane by a half-turn flip
   assign fill_a     = {fill_idx_ff, {(32-TABLE_BITS){1'b0}}};
   assign fill_a_q   = fill_a + QUARTER;
   assign fill_flip  = fill_a_q[31];
   assign fill_a_rot = fill_flip ? fill_a + HALF_TURN : fill_a;

   assign cx_rnd = cx + DW'(16384);
   assign cy_rnd = cy + DW'(16384);
   assign tc_sh  = cx_rnd[DW-1:15];
   assign ts_sh  = cy_rnd[DW-1:15];
   assign tc_cl  = (tc_sh < TMIN) ? TMIN : ((tc_sh > TMAX) ? TMAX : tc_sh);
   assign ts_cl  = (ts_sh < TMIN) ? TMIN : ((ts_sh > TMAX) ? TMAX : ts_sh);
   assign tc     = flip_ff ? -tc_cl[15:0] : tc_cl[15:0];
   assign ts     = flip_ff ? -ts_cl[15:0] : ts_cl[15:0];
   assign rom_wdata = {tc, ts};

   assign re_rnd = re_ff + MIX_W'(16384);
   assign im_rnd = im_ff + MIX_W'(16384);
   assign re_sh  = re_rnd[MIX_W-1:15];
   assign im_sh  = im_rnd[MIX_W-1:15];
   assign re_cl  = (re_sh < SMIN) ? SMIN : ((re_sh > SMAX) ? SMAX : re_sh);
   assign im_cl  = (im_sh < SMIN) ? SMIN : ((im_sh > SMAX) ? SMAX : im_sh);
   assign re_ext = DW'(re_ff);
   assign im_ext = DW'(im_ff);

   assign z_rnd     = cz[31:0] + 32'h0000_8000;
   assign prod_rnd  = prod_ff + PW'(32768);
   assign gain_term = prod_rnd[48:16];
   assign lo_ext    = 34'(signed'(lo_ff));
   assign hi_ext    = 34'(signed'(hi_ff));

   // single shared multiplier: four mixer products, then the two gain products
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_MIX_MUL: begin
            case (cnt_ff)
               5'd1: begin
                  mul_a = 33'(rom_s);
                  mul_b = MB'(sq_ff);
               end
               5'd2: begin
                  mul_a = 33'(rom_c);
                  mul_b = MB'(sq_ff);
               end
               5'd3: begin
                  mul_a = 33'(rom_s);
                  mul_b = MB'(si_ff);
               end
               default: begin
                  mul_a = 33'(rom_c);
                  mul_b = MB'(si_ff);
               end
            endcase
         end
         ST_GAIN: begin
            mul_a = (cnt_ff == '0) ? {1'b0, beta_ff} : {1'b0, alpha_ff};
            mul_b = MB'(err_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = PW'(mul_a) * PW'(mul_b);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      fill_idx_in  = fill_idx_ff;
      flip_in      = flip_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      start_in     = start_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      alpha_in     = alpha_ff;
      beta_in      = beta_ff;
      freq_in      = freq_ff;
      phase_in     = phase_ff;
      si_in        = si_ff;
      sq_in        = sq_ff;
      re_in        = re_ff;
      im_in        = im_ff;
      mi_in        = mi_ff;
      mq_in        = mq_ff;
      zero_in      = zero_ff;
      err_in       = err_ff;
      f_in         = f_ff;
      pterm_in     = pterm_ff;
      fnew_in      = fnew_ff;
      lock_in      = lock_ff;
      out_mi_in    = out_mi_ff;
      out_mq_in    = out_mq_ff;
      out_err_in   = out_err_ff;
      out_freq_in  = out_freq_ff;
      out_phase_in = out_phase_ff;
      out_lock_in  = out_lock_ff;
      rom_we       = 1'b0;
      cctrl        = '{load: 1'b0, step: 1'b0, vectoring: 1'b0, index: cnt_ff};
      cx_init      = DW'(ROT_X0);
      cy_init      = '0;
      cz_init      = ZW'(signed'(fill_a_rot));

      case (state_ff)
         ST_FILL_INIT: begin
            cctrl.load = 1'b1;
            flip_in    = fill_flip;
            cnt_in     = '0;
            state_in   = ST_FILL_ITER;
         end
         ST_FILL_ITER: begin
            cctrl.step = 1'b1;
            cnt_in     = cnt_ff + 1'b1;
            if (cnt_ff == FILL_LAST) begin
               state_in = ST_FILL_WRITE;
            end
         end
         ST_FILL_WRITE: begin
            rom_we      = 1'b1;
            fill_idx_in = fill_idx_ff + 1'b1;
            state_in    = (fill_idx_ff == '1) ? ST_IDLE : ST_FILL_INIT;
         end
         ST_IDLE: begin
            if (req_take) begin
               si_in    = req_bus.sample_i;
               sq_in    = req_bus.sample_q;
               cnt_in   = '0;
               state_in = ST_MIX_MUL;
            end
         end
         ST_MIX_MUL: begin
            cnt_in = cnt_ff + 1'b1;
            case (cnt_ff)
               5'd1: re_in = MIX_W'(prod_ff);
               5'd2: re_in = re_ff + MIX_W'(prod_ff);
               5'd3: im_in = MIX_W'(prod_ff);
               5'd4: begin
                  im_in    = im_ff - MIX_W'(prod_ff);
                  state_in = ST_MIX_SAT;
               end
               default: begin
               end
            endcase
         end
         ST_MIX_SAT: begin
            mi_in      = re_cl[SAMPLE_BITS-1:0];
            mq_in      = im_cl[SAMPLE_BITS-1:0];
            zero_in    = (re_ff == '0) && (im_ff == '0);
            // left half-plane: rotate by half a turn before vectoring
            cctrl.load = 1'b1;
            if (re_ff[MIX_W-1]) begin
               cx_init = -re_ext;
               cy_init = -im_ext;
               cz_init = {2'b00, HALF_TURN};
            end else begin
               cx_init = re_ext;
               cy_init = im_ext;
               cz_init = '0;
            end
            cnt_in   = '0;
            state_in = ST_VECTOR;
         end
         ST_VECTOR: begin
            cctrl.step      = 1'b1;
            cctrl.vectoring = 1'b1;
            cnt_in          = cnt_ff + 1'b1;
            if (cnt_ff == VEC_LAST) begin
               state_in = ST_ERROR;
            end
         end
         ST_ERROR: begin
            err_in   = zero_ff ? 16'sd0 : z_rnd[31:16];
            cnt_in   = '0;
            state_in = ST_GAIN;
         end
         ST_GAIN: begin
            cnt_in = cnt_ff + 1'b1;
            case (cnt_ff)
               5'd1: f_in = 34'(signed'(freq_ff)) + 34'(gain_term);
               5'd2: begin
                  pterm_in = gain_term[31:0];
                  if (f_ff < lo_ext) begin
                     fnew_in = lo_ff;
                     lock_in = 1'b0;
                  end else if (f_ff > hi_ext) begin
                     fnew_in = hi_ff;
                     lock_in = 1'b0;
                  end else begin
                     fnew_in = f_ff[31:0];
                     lock_in = 1'b1;
                  end
                  state_in = ST_UPDATE;
               end
               default: begin
               end
            endcase
         end
         ST_UPDATE: begin
            if (out_free) begin
               freq_in      = fnew_ff;
               phase_in     = (phase_ff + fnew_ff + pterm_ff) & PHASE_MASK;
               out_mi_in    = mi_ff;
               out_mq_in    = mq_ff;
               out_err_in   = err_ff;
               out_freq_in  = fnew_ff;
               out_phase_in = (phase_ff + fnew_ff + pterm_ff) & PHASE_MASK;
               out_lock_in  = lock_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (cfg_we) begin
         case (csr_index_type'(csr_bus.index))
            CSR_START_INCREMENT: begin
               start_in = csr_bus.data;
               freq_in  = csr_bus.data;
            end
            CSR_LOW_LIMIT:  lo_in    = csr_bus.data;
            CSR_HIGH_LIMIT: hi_in    = csr_bus.data;
            CSR_PROP_GAIN:  alpha_in = csr_bus.data;
            CSR_INT_GAIN:   beta_in  = csr_bus.data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FILL_INIT;
         cnt_ff       <= '0;
         fill_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         start_ff     <= '0;
         lo_ff        <= 32'h8000_0000;
         hi_ff        <= 32'h7FFF_FFFF;
         alpha_ff     <= '0;
         beta_ff      <= '0;
         freq_ff      <= '0;
         phase_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         fill_idx_ff  <= fill_idx_in;
         rsp_valid_ff <= rsp_valid_in;
         start_ff     <= start_in;
         lo_ff        <= lo_in;
         hi_ff        <= hi_in;
         alpha_ff     <= alpha_in;
         beta_ff      <= beta_in;
         freq_ff      <= freq_in;
         phase_ff     <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      flip_ff      <= flip_in;
      si_ff        <= si_in;
      sq_ff        <= sq_in;
      prod_ff      <= prod_in;
      re_ff        <= re_in;
      im_ff        <= im_in;
      mi_ff        <= mi_in;
      mq_ff        <= mq_in;
      zero_ff      <= zero_in;
      err_ff       <= err_in;
      f_ff         <= f_in;
      pterm_ff     <= pterm_in;
      fnew_ff      <= fnew_in;
      lock_ff      <= lock_in;
      out_mi_ff    <= out_mi_in;
      out_mq_ff    <= out_mq_in;
      out_err_ff   <= out_err_in;
      out_freq_ff  <= out_freq_in;
      out_phase_ff <= out_phase_in;
      out_lock_ff  <= out_lock_in;
   end

   // cos/sin table, filled once after reset
   always_ff @(posedge clock) begin
      if (rom_we) begin
         rom_mem[fill_idx_ff] <= rom_wdata;
      end
      rom_q_ff <= rom_mem[phase_ff[31 -: TABLE_BITS]];
   end

   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.mixed_i          = out_mi_ff;
   assign rsp_bus.mixed_q          = out_mq_ff;
   assign rsp_bus.phase_error      = out_err_ff;
   assign rsp_bus.frequency_now    = out_freq_ff;
   assign rsp_bus.oscillator_phase = out_phase_ff;
   assign rsp_bus.in_lock          = out_lock_ff;

   a_word_from_update: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_UPDATE))
      else $error("result word raised outside the update step");

   a_take_starts_mix: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == ST_MIX_MUL) && (cnt_ff == '0))
      else $error("accepted sample did not start the mixer");

   a_commit_loads_word: assert property (@(posedge clock) disable iff (reset)
      commit |=> rsp_valid_ff)
      else $error("loop update without a result word");

   a_vector_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_VECTOR) |-> (cnt_ff <= VEC_LAST))
      else $error("vectoring ran past its step count");

   a_phase_resolution: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((out_phase_ff & ~PHASE_MASK) == '0))
      else $error("phase word carries bits below the phase resolution");

endmodule

// ----- sim/tb.sv -----
// testbench of the carrier loop: directed corners, then randomised loop settings and tone input
module tb import sopll_pkg::*; ();

   localparam int TBL_BITS   = 10;
   localparam int PHASE_RES  = 32;
   localparam int SMP_BITS   = 16;
   localparam int VEC_STEPS  = 16;
   localparam int ROT_STEPS  = 24;
   localparam int RANDOM_ITEMS = 1450;
   localparam logic [31:0] PHASE_MASK = 32'hFFFF_FFFF << (32 - PHASE_RES);
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_FIRST = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LAST  = 3'd7;
   // arctangent of 2^-k in 2^-32 turns
   localparam longint ARCTAN_STEP [0:ROT_STEPS-1] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772,
      166886, 83443, 41722, 20861, 10430, 5215,
      2608, 1304, 652, 326, 163, 81};

   typedef struct {
      logic signed [15:0] mixed_i;
      logic signed [15:0] mixed_q;
      logic signed [15:0] phase_error;
      logic signed [31:0] frequency_now;
      logic [31:0]        oscillator_phase;
      logic               in_lock;
   } loop_word_type;

   class carrier_loop_scoreboard;
      logic [31:0] cos_sin_rom [1 << TBL_BITS];
      logic [31:0] phase_acc, freq_inc, start_inc, low_limit, high_limit;
      logic [31:0] alpha_gain, beta_gain;
      loop_word_type expected_q [$];
      int          errors;
      int          words;

      function new();
         for (int n = 0; n < (1 << TBL_BITS); n++) cos_sin_rom[n] = table_entry(n);
         start_inc  = '0;
         low_limit  = 32'h8000_0000;
         high_limit = 32'h7FFF_FFFF;
         alpha_gain = '0;
         beta_gain  = '0;
         phase_acc  = '0;
         freq_inc   = start_inc;
         errors     = 0;
         words      = 0;
      endfunction

      function longint clamp(longint v, longint lo, longint hi);
         return v < lo ? lo : (v > hi ? hi : v);
      endfunction

      // cos in the upper half, sin in the lower, both q1.15
      function logic [31:0] table_entry(int n);
         logic [31:0] a, t;
         bit          flip;
         longint      x, y, z, dx, dy, c, s;
         a = {n[TBL_BITS-1:0], {(32-TBL_BITS){1'b0}}};
         t = a + 32'h4000_0000;
         flip = t[31];
         if (flip) a = a + 32'h8000_0000;
         z = longint'($signed(a));
         x = 652032874;
         y = 0;
         for (int k = 0; k < ROT_STEPS; k++) begin
            dx = y >>> k;
            dy = x >>> k;
            if (z >= 0) begin
               x -= dx; y += dy; z -= ARCTAN_STEP[k];
            end else begin
               x += dx; y -= dy; z += ARCTAN_STEP[k];
            end
         end
         c = clamp((x + 16384) >>> 15, -32767, 32767);
         s = clamp((y + 16384) >>> 15, -32767, 32767);
         if (flip) begin
            c = -c;
            s = -s;
         end
         return {c[15:0], s[15:0]};
      endfunction

      function logic [31:0] vector_turns(longint x, longint y);
         logic [31:0] z;
         longint      dx, dy;
         z = '0;
         if (x < 0) begin
            x = -x;
            y = -y;
            z = 32'h8000_0000;
         end
         for (int k = 0; k < VEC_STEPS && k < ROT_STEPS; k++) begin
            dx = y >>> k;
            dy = x >>> k;
            if (y > 0) begin
               x += dx; y -= dy; z = z + 32'(ARCTAN_STEP[k]);
            end else begin
               x -= dx; y += dy; z = z - 32'(ARCTAN_STEP[k]);
            end
         end
         return z;
      endfunction

      function void apply_register(logic [CSR_INDEX_W-1:0] idx, logic [31:0] data);
         case (idx)
            CSR_START_INCREMENT: begin
               start_inc = data;
               freq_inc  = data;
            end
            CSR_LOW_LIMIT:  low_limit  = data;
            CSR_HIGH_LIMIT: high_limit = data;
            CSR_PROP_GAIN:  alpha_gain = data;
            CSR_INT_GAIN:   beta_gain  = data;
            default: ;
         endcase
      endfunction

      // one accepted sample: mix, detect, filter, advance the oscillator
      function void note_sample(logic signed [15:0] si, logic signed [15:0] sq);
         logic [31:0] entry, z;
         longint      c, s, re, im, err, f, lo, hi, pterm, mi, mq;
         loop_word_type w;
         entry = cos_sin_rom[phase_acc[31 -: TBL_BITS]];
         c  = longint'($signed(entry[31:16]));
         s  = longint'($signed(entry[15:0]));
         re = longint'(si) * c + longint'(sq) * s;
         im = longint'(sq) * c - longint'(si) * s;
         mi = clamp((re + 16384) >>> 15, -32768, 32767);
         mq = clamp((im + 16384) >>> 15, -32768, 32767);
         err = 0;
         if (re != 0 || im != 0) begin
            z = vector_turns(re, im) + 32'h8000;
            err = longint'($signed(z[31:16]));
         end
         f  = longint'($signed(freq_inc))
              + ((longint'({32'b0, beta_gain}) * err + 32768) >>> 16);
         lo = longint'($signed(low_limit));
         hi = longint'($signed(high_limit));
         w.in_lock = 1'b0;
         // low bound tested first, which decides crossed limits
         if (f < lo) f = lo;
         else if (f > hi) f = hi;
         else w.in_lock = 1'b1;
         freq_inc = f[31:0];
         pterm = (longint'({32'b0, alpha_gain}) * err + 32768) >>> 16;
         phase_acc = (phase_acc + freq_inc + pterm[31:0]) & PHASE_MASK;
         w.mixed_i          = mi[15:0];
         w.mixed_q          = mq[15:0];
         w.phase_error      = err[15:0];
         w.frequency_now    = freq_inc;
         w.oscillator_phase = phase_acc;
         expected_q.push_back(w);
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      task report_mismatch(string msg);
         errors++;
         $display("[%0t] mismatch: %s", $time, msg);
      endtask

      task check_word(loop_word_type got);
         loop_word_type w;
         string      diffs;
         if (expected_q.size() == 0) begin
            report_mismatch("result word with nothing expected");
            return;
         end
         w = expected_q.pop_front();
         diffs = "";
         if (got.mixed_i !== w.mixed_i)
            diffs = {diffs, $sformatf(" mixed_i %0d/%0d", got.mixed_i, w.mixed_i)};
         if (got.mixed_q !== w.mixed_q)
            diffs = {diffs, $sformatf(" mixed_q %0d/%0d", got.mixed_q, w.mixed_q)};
         if (got.phase_error !== w.phase_error)
            diffs = {diffs, $sformatf(" phase_error %0d/%0d", got.phase_error, w.phase_error)};
         if (got.frequency_now !== w.frequency_now)
            diffs = {diffs, $sformatf(" frequency_now %0d/%0d",
                                      got.frequency_now, w.frequency_now)};
         if (got.oscillator_phase !== w.oscillator_phase)
            diffs = {diffs, $sformatf(" oscillator_phase %h/%h",
                                      got.oscillator_phase, w.oscillator_phase)};
         if (got.in_lock !== w.in_lock)
            diffs = {diffs, $sformatf(" in_lock %b/%b", got.in_lock, w.in_lock)};
         if (diffs != "") report_mismatch($sformatf("word %0d (got/want):%s", words, diffs));
         words++;
      endtask
   endclass

   logic clock;
   logic reset;
   bit   quiet;

   sopll_req_if #(.SAMPLE_BITS(SMP_BITS)) req_bus ();
   sopll_rsp_if #(.SAMPLE_BITS(SMP_BITS)) rsp_bus ();
   sopll_csr_if csr_bus ();

   second_order_carrier_pll_unit #(
      .TABLE_BITS  (TBL_BITS),
      .PHASE_BITS  (PHASE_RES),
      .SAMPLE_BITS (SMP_BITS),
      .CORDIC_STEPS(VEC_STEPS)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_bus(csr_bus)
   );

   carrier_loop_scoreboard sb = new();

   // tone generator state
   logic [31:0] tone_phase, tone_step;
   int          tone_amp, noise_amp;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   initial begin
      #6000000;
      $display("[second_order_carrier_pll_unit] ERROR");
      $finish;
   end

   // result side: rare stall bursts, none while quiet
   initial begin
      int hold;
      hold = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold > 0) begin
            hold--;
            rsp_bus.ready <= 1'b0;
         end else if (!quiet && $urandom_range(99) == 0) begin
            hold = $urandom_range(0, 11);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      loop_word_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.mixed_i          = rsp_bus.mixed_i;
         got.mixed_q          = rsp_bus.mixed_q;
         got.phase_error      = rsp_bus.phase_error;
         got.frequency_now    = rsp_bus.frequency_now;
         got.oscillator_phase = rsp_bus.oscillator_phase;
         got.in_lock          = rsp_bus.in_lock;
         sb.check_word(got);
      end
   end

   function automatic logic [15:0] clip16(int v);
      if (v > 32767) return 16'h7FFF;
      if (v < -32768) return 16'h8000;
      return v[15:0];
   endfunction

   task automatic send_sample(logic [15:0] si, logic [15:0] sq);
      req_bus.valid    <= 1'b1;
      req_bus.sample_i <= si;
      req_bus.sample_q <= sq;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      sb.note_sample(si, sq);
   endtask

   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // sends one word, then now and then leaves a gap or waits for the loop to empty
   task automatic send_and_idle(logic [15:0] si, logic [15:0] sq);
      send_sample(si, sq);
      if (!quiet && $urandom_range(99) < 10) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 35)) @(posedge clock);
      end else if (!quiet && $urandom_range(99) < 2) begin
         drain_results();
      end
   endtask

   task automatic write_register(logic [CSR_INDEX_W-1:0] idx, logic [31:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= data;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      sb.apply_register(idx, data);
   endtask

   task automatic program_loop(logic [31:0] start, logic [31:0] lo, logic [31:0] hi,
                               logic [31:0] alpha, logic [31:0] beta, bit spares);
      write_register(CSR_LOW_LIMIT, lo);
      write_register(CSR_HIGH_LIMIT, hi);
      write_register(CSR_PROP_GAIN, alpha);
      write_register(CSR_INT_GAIN, beta);
      write_register(CSR_START_INCREMENT, start);
      // unused indexes must leave the settings alone
      if (spares)
         for (int k = CSR_SPARE_FIRST; k <= CSR_SPARE_LAST; k++)
            write_register(k[CSR_INDEX_W-1:0], $urandom);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic next_random_sample(output logic [15:0] si, output logic [15:0] sq);
      logic [31:0] entry;
      int          pick;
      logic [15:0] corners [5];
      corners = '{16'h8000, 16'hFFFF, 16'h0000, 16'h0001, 16'h7FFF};
      pick = $urandom_range(99);
      if (pick < 70) begin
         entry = sb.cos_sin_rom[tone_phase[31 -: TBL_BITS]];
         si = clip16(((int'($signed(entry[31:16])) * tone_amp) >>> 15)
                     + int'($urandom_range(0, 2 * noise_amp)) - noise_amp);
         sq = clip16(((int'($signed(entry[15:0])) * tone_amp) >>> 15)
                     + int'($urandom_range(0, 2 * noise_amp)) - noise_amp);
         tone_phase = tone_phase + tone_step;
      end else if (pick < 85) begin
         si = 16'($urandom);
         sq = 16'($urandom);
      end else begin
         si = corners[$urandom_range(0, 4)];
         sq = corners[$urandom_range(0, 4)];
      end
   endtask

   initial begin
      logic [31:0] corner_words [12];
      logic [31:0] clamp_words [5];
      logic [31:0] crossed_words [5];
      logic [31:0] start, lo, hi, alpha, beta, width;
      logic [15:0] si, sq;
      int          sent, phase_no, count;

      corner_words = '{{16'h7FFF, 16'h7FFF}, {16'h8000, 16'h8000}, {16'h7FFF, 16'h8000},
                       {16'h8000, 16'h7FFF}, {16'h0000, 16'h0000}, {16'h0001, 16'h0000},
                       {16'h0000, 16'h0001}, {16'hFFFF, 16'h0000}, {16'h0000, 16'hFFFF},
                       {16'h8000, 16'h0000}, {16'h0000, 16'h7FFF}, {16'h3039, 16'hA460}};
      clamp_words  = '{{16'h8000, 16'h8000}, {16'h7FFF, 16'h0000}, {16'h0000, 16'h8000},
                       {16'h0000, 16'h0000}, {16'h5A5A, 16'hA5A5}};
      crossed_words = '{{16'h4000, 16'h0000}, {16'h0000, 16'h4000}, {16'hC000, 16'h0000},
                        {16'h0000, 16'hC000}, {16'h7FFF, 16'h7FFF}};

      quiet = 1'b0;
      reset = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.sample_i = '0;
      req_bus.sample_q = '0;
      csr_bus.valid    = 1'b0;
      csr_bus.index    = '0;
      csr_bus.data     = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // corners of the sample range, including a zero product
      program_loop(32'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1000_0000, 32'h0010_0000, 1'b1);
      foreach (corner_words[k]) send_and_idle(corner_words[k][31:16], corner_words[k][15:0]);
      drain_results();

      // largest gains from the top increment, so the high clamp is hit
      program_loop(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      foreach (clamp_words[k]) send_and_idle(clamp_words[k][31:16], clamp_words[k][15:0]);
      drain_results();

      // crossed limits: low above high
      program_loop(32'h0000_0000, 32'h1000_0000, 32'hF000_0000,
                   32'h0800_0000, 32'h0100_0000, 1'b0);
      foreach (crossed_words[k])
         send_and_idle(crossed_words[k][31:16], crossed_words[k][15:0]);
      drain_results();

      sent = 0;
      phase_no = 0;
      while (sent < RANDOM_ITEMS) begin
         tone_step  = $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
         tone_amp   = $urandom_range(1000, 32767);
         noise_amp  = $urandom_range(0, 3000);
         tone_phase = $urandom;
         case ($urandom_range(0, 3))
            0: start = tone_step + $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
            1: start = $urandom;
            2: start = 32'h8000_0000;
            default: start = 32'h7FFF_FFFF;
         endcase
         width = $urandom_range(1, 32'h0800_0000);
         case ($urandom_range(0, 4))
            0: begin lo = 32'h8000_0000; hi = 32'h7FFF_FFFF; end
            1: begin lo = start - width; hi = start + width; end
            2: begin lo = start + width; hi = start - width; end
            3: begin lo = $urandom; hi = $urandom; end
            default: begin lo = start; hi = start; end
         endcase
         case ($urandom_range(0, 4))
            0: alpha = 32'h0;
            1: alpha = 32'hFFFF_FFFF;
            2: alpha = $urandom;
            default: alpha = $urandom_range(32'h0100_0000, 32'h2000_0000);
         endcase
         case ($urandom_range(0, 4))
            0: beta = 32'h0;
            1: beta = 32'hFFFF_FFFF;
            2: beta = $urandom;
            default: beta = $urandom_range(32'h0001_0000, 32'h0100_0000);
         endcase
         // one phase runs flat out on both sides
         quiet = (phase_no == 2);
         program_loop(start, lo, hi, alpha, beta, $urandom_range(0, 3) == 0);
         count = $urandom_range(60, 160);
         for (int k = 0; k < count && sent < RANDOM_ITEMS; k++) begin
            next_random_sample(si, sq);
            send_and_idle(si, sq);
            sent++;
         end
         drain_results();
         phase_no++;
      end

      quiet = 1'b0;
      repeat (40) @(posedge clock);
      if (sb.errors == 0)
         $display("[second_order_carrier_pll_unit] OK");
      else
         $display("[second_order_carrier_pll_unit] ERROR");
      $finish;
   end

endmodule

// ----- second_order_carrier_pll_unit.f -----
rtl/sopll_pkg.sv
rtl/sopll_if.sv
rtl/sopll_cordic.sv
rtl/second_order_carrier_pll_unit.sv
sim/tb.sv
